### rtl/fdd_pkg.sv
// shared types and constants for the framed delta decoder with record statistics
package fdd_pkg;

   localparam int COUNT_BITS_DEF = 24;
   localparam int FRAME_LEN_RESET = 50;
   localparam int VALUE_W = 32;
   localparam int SUM_W = 56;
   localparam int AVG_W = 40;
   localparam int TOTAL_W = 24;
   localparam int CNT_FIELD_W = 32;
   localparam int FLEN_W = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int NUM_W = SUM_W + 8;
   localparam int DIV_STEPS = NUM_W;
   localparam int STEP_W = $clog2(DIV_STEPS);

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic signed [VALUE_W-1:0] coded_sample;
      logic                      record_end;
   } req_type;

   typedef struct packed {
      logic                      kind;
      logic signed [VALUE_W-1:0] decoded_value;
      logic signed [VALUE_W-1:0] maximum;
      logic signed [VALUE_W-1:0] minimum;
      logic signed [AVG_W-1:0]   average;
      logic [TOTAL_W-1:0]        total_count;
      logic                      last;
   } rsp_type;

   // one decoded sample plus the record statistics after it
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      record_end;
      logic signed [VALUE_W-1:0] maximum;
      logic signed [VALUE_W-1:0] minimum;
      logic [SUM_W-1:0]          sum;
      logic [CNT_FIELD_W-1:0]    count;
   } entry_type;

endpackage

### rtl/fdd_front.sv
// front part: delta decode and running record statistics
module fdd_front #(
   parameter int COUNT_BITS = fdd_pkg::COUNT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   input  logic [fdd_pkg::FLEN_W-1:0] csr_data,
   input  logic                      take,
   input  fdd_pkg::req_type          req_data,
   output fdd_pkg::entry_type        entry
);

   logic [fdd_pkg::FLEN_W-1:0]  flen_ff;
   logic [fdd_pkg::FLEN_W-1:0]  pos_ff, pos_in;
   logic [fdd_pkg::VALUE_W-1:0] prev_ff;
   logic [fdd_pkg::VALUE_W-1:0] max_ff, max_in;
   logic [fdd_pkg::VALUE_W-1:0] min_ff, min_in;
   logic [fdd_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_BITS-1:0]       cnt_ff, cnt_in;
   logic [fdd_pkg::VALUE_W-1:0] value;
   logic [fdd_pkg::FLEN_W-1:0]  flen_eff;
   logic [fdd_pkg::FLEN_W:0]    pos_inc;
   logic [COUNT_BITS+fdd_pkg::CNT_FIELD_W-1:0] cnt_ext;

   always_comb begin
      flen_eff = (flen_ff == '0) ? fdd_pkg::FLEN_W'(1) : flen_ff;
      value = (pos_ff == '0) ? req_data.coded_sample : prev_ff + req_data.coded_sample;
      pos_inc = {1'b0, pos_ff} + 1'b1;
      pos_in = (pos_inc >= {1'b0, flen_eff}) ? '0 : pos_inc[fdd_pkg::FLEN_W-1:0];
      if (cnt_ff == '0) begin
         max_in = value;
         min_in = value;
      end else begin
         max_in = ($signed(value) > $signed(max_ff)) ? value : max_ff;
         min_in = ($signed(value) < $signed(min_ff)) ? value : min_ff;
      end
      sum_in = sum_ff + {{(fdd_pkg::SUM_W-fdd_pkg::VALUE_W){value[fdd_pkg::VALUE_W-1]}}, value};
      // count saturates at all ones
      cnt_in = (cnt_ff == '1) ? cnt_ff : cnt_ff + 1'b1;
      cnt_ext = {{fdd_pkg::CNT_FIELD_W{1'b0}}, cnt_in};
      entry.value = value;
      entry.record_end = req_data.record_end;
      entry.maximum = max_in;
      entry.minimum = min_in;
      entry.sum = sum_in;
      entry.count = cnt_ext[fdd_pkg::CNT_FIELD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flen_ff <= fdd_pkg::FLEN_W'(fdd_pkg::FRAME_LEN_RESET);
      end else if (csr_valid) begin
         flen_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         prev_ff <= '0;
         max_ff <= '0;
         min_ff <= '0;
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (take) begin
         if (req_data.record_end) begin
            pos_ff <= '0;
            prev_ff <= '0;
            max_ff <= '0;
            min_ff <= '0;
            sum_ff <= '0;
            cnt_ff <= '0;
         end else begin
            pos_ff <= pos_in;
            prev_ff <= value;
            max_ff <= max_in;
            min_ff <= min_in;
            sum_ff <= sum_in;
            cnt_ff <= cnt_in;
         end
      end
   end

endmodule

### rtl/fdd_queue.sv
// short queue of decoded entries between front and back
module fdd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fdd_pkg::entry_type din,
   input  logic               pop,
   output fdd_pkg::entry_type dout,
   output logic               full,
   output logic               empty
);

   localparam int PTR_W = $clog2(fdd_pkg::QUEUE_DEPTH);

   fdd_pkg::entry_type  mem_ff [fdd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ff;
   logic [PTR_W-1:0]    rd_ff;
   logic [PTR_W:0]      fill_ff;

   assign full = (fill_ff == (PTR_W+1)'(fdd_pkg::QUEUE_DEPTH));
   assign empty = (fill_ff == '0);
   assign dout = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

### rtl/fdd_back.sv
// back part: sample results, record average by bit-serial division, summary results
module fdd_back (
   input  logic               clock,
   input  logic               reset,
   input  fdd_pkg::entry_type entry,
   input  logic               empty,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fdd_pkg::rsp_type   rsp_data
);

   typedef enum logic [2:0] {
      ST_PASS = 3'b001,
      ST_DIV  = 3'b010,
      ST_SUM  = 3'b100
   } state_type;

   localparam int NW = fdd_pkg::NUM_W;
   localparam int DW = fdd_pkg::CNT_FIELD_W;

   state_type                     state_ff, state_in;
   logic                          valid_ff;
   fdd_pkg::rsp_type              out_ff;
   logic [fdd_pkg::VALUE_W-1:0]   max_ff;
   logic [fdd_pkg::VALUE_W-1:0]   min_ff;
   logic [DW-1:0]                 cnt_ff;
   logic [DW-1:0]                 div_ff;
   logic                          neg_ff;
   logic [NW-1:0]                 num_ff;
   logic [NW-1:0]                 quo_ff;
   logic [DW-1:0]                 rem_ff;
   logic [fdd_pkg::STEP_W-1:0]    step_ff;
   logic                          out_free;
   logic [DW:0]                   shifted;
   logic                          ge;
   logic [DW:0]                   diff;
   logic [fdd_pkg::SUM_W-1:0]     mag;
   logic [NW-1:0]                 q_sat;
   logic [fdd_pkg::AVG_W-1:0]     avg;
   fdd_pkg::rsp_type              sample_rsp;
   fdd_pkg::rsp_type              summary_rsp;

   assign out_free = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data = out_ff;
   assign pop = (state_ff == ST_PASS) && !empty && out_free;

   always_comb begin
      mag = entry.sum[fdd_pkg::SUM_W-1] ? (~entry.sum + 1'b1) : entry.sum;
      shifted = {rem_ff, num_ff[NW-1]};
      diff = shifted - {1'b0, div_ff};
      ge = (shifted >= {1'b0, div_ff});
      // clamp to the signed 40-bit range
      if (neg_ff) begin
         q_sat = (quo_ff > (NW'(1) << (fdd_pkg::AVG_W-1))) ?
                 (NW'(1) << (fdd_pkg::AVG_W-1)) : quo_ff;
         avg = fdd_pkg::AVG_W'(~q_sat + 1'b1);
      end else begin
         q_sat = (quo_ff > ((NW'(1) << (fdd_pkg::AVG_W-1)) - 1'b1)) ?
                 ((NW'(1) << (fdd_pkg::AVG_W-1)) - 1'b1) : quo_ff;
         avg = q_sat[fdd_pkg::AVG_W-1:0];
      end

      sample_rsp = '0;
      sample_rsp.kind = fdd_pkg::KIND_SAMPLE;
      sample_rsp.decoded_value = entry.value;
      sample_rsp.last = !entry.record_end;

      summary_rsp = '0;
      summary_rsp.kind = fdd_pkg::KIND_SUMMARY;
      summary_rsp.maximum = max_ff;
      summary_rsp.minimum = min_ff;
      summary_rsp.average = avg;
      summary_rsp.total_count = cnt_ff[fdd_pkg::TOTAL_W-1:0];
      summary_rsp.last = 1'b1;

      state_in = state_ff;
      unique case (state_ff)
         ST_PASS: begin
            if (pop && entry.record_end) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (step_ff == '0) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (out_free) begin
               state_in = ST_PASS;
            end
         end
         default: state_in = ST_PASS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_PASS;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (pop || (state_ff == ST_SUM && out_free)) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= sample_rsp;
      end else if (state_ff == ST_SUM && out_free) begin
         out_ff <= summary_rsp;
      end
      if (pop && entry.record_end) begin
         max_ff <= entry.maximum;
         min_ff <= entry.minimum;
         cnt_ff <= entry.count;
         div_ff <= (entry.count == '0) ? DW'(1) : entry.count;
         neg_ff <= entry.sum[fdd_pkg::SUM_W-1];
         num_ff <= {mag, 8'b0};
         quo_ff <= '0;
         rem_ff <= '0;
         step_ff <= fdd_pkg::STEP_W'(fdd_pkg::DIV_STEPS - 1);
      end else if (state_ff == ST_DIV) begin
         // one restoring division step per cycle
         rem_ff <= ge ? diff[DW-1:0] : shifted[DW-1:0];
         quo_ff <= {quo_ff[NW-2:0], ge};
         num_ff <= {num_ff[NW-2:0], 1'b0};
         step_ff <= step_ff - 1'b1;
      end
   end

endmodule

### rtl/framed_delta_decoder_with_stats.sv
// top level of the framed delta decoder with record statistics
//
//   channel   direction  handshake                payload
//   req_      in         req_valid / req_stall     fdd_pkg::req_type
//   rsp_      out        rsp_valid / rsp_stall     fdd_pkg::rsp_type
//   csr_      in         csr_valid / csr_ready     frame_length, 8 bits
//
// the front decodes one request per cycle while the 4-entry queue has room.
// each request gives one sample result per cycle from the back while rsp_stall is low
// and no record summary is pending; a record end adds a summary after its sample result,
// once the bit-serial average divider is done. synchronous reset clears all record
// state and sets frame_length to 50. rsp_stall holds the output register; the queue
// absorbs requests until it fills, then req_stall rises.
module framed_delta_decoder_with_stats #(
   parameter int COUNT_BITS = fdd_pkg::COUNT_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  fdd_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output fdd_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [fdd_pkg::FLEN_W-1:0] csr_data
);

   fdd_pkg::entry_type front_entry;
   fdd_pkg::entry_type queue_entry;
   logic               take;
   logic               full;
   logic               empty;
   logic               pop;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign take = req_valid && !full;

   fdd_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid && csr_ready),
      .csr_data (csr_data),
      .take     (take),
      .req_data (req_data),
      .entry    (front_entry)
   );

   fdd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push (take),
      .din  (front_entry),
      .pop  (pop),
      .dout (queue_entry),
      .full (full),
      .empty(empty)
   );

   fdd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .entry    (queue_entry),
      .empty    (empty),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the framed delta decoder with record statistics
import fdd_pkg::*;

class stats_scoreboard;
   logic [FLEN_W-1:0]         frame_len;
   logic [VALUE_W-1:0]        prev_value;
   logic [FLEN_W-1:0]         frame_pos;
   logic signed [VALUE_W-1:0] run_max;
   logic signed [VALUE_W-1:0] run_min;
   logic [SUM_W-1:0]          run_sum;
   logic [COUNT_BITS_DEF-1:0] sample_cnt;
   rsp_type                   expected_q[$];
   int                        errors;

   function new();
      frame_len = FLEN_W'(FRAME_LEN_RESET);
      errors = 0;
      clear_record();
   endfunction

   function void clear_record();
      prev_value = '0;
      frame_pos = '0;
      run_max = '0;
      run_min = '0;
      run_sum = '0;
      sample_cnt = '0;
   endfunction

   // sum * 256 / count as signed q.8, truncated toward zero and saturated to 40 bits
   function logic [AVG_W-1:0] record_mean();
      logic [SUM_W-1:0] mag;
      logic [63:0]      num;
      logic [63:0]      q;
      logic [63:0]      cnt;
      mag = run_sum[SUM_W-1] ? (~run_sum + 1'b1) : run_sum;
      cnt = (sample_cnt == 0) ? 64'd1 : 64'(sample_cnt);
      num = {mag, 8'h00};
      q = num / cnt;
      if (run_sum[SUM_W-1]) begin
         if (q > 64'h80_0000_0000) q = 64'h80_0000_0000;
         q = ~q + 64'd1;
         return q[AVG_W-1:0];
      end
      if (q > 64'h7F_FFFF_FFFF) q = 64'h7F_FFFF_FFFF;
      return q[AVG_W-1:0];
   endfunction

   function void note_req(req_type r);
      rsp_type                   sample_rsp;
      rsp_type                   summary_rsp;
      logic signed [VALUE_W-1:0] value;
      logic [FLEN_W-1:0]         flen;
      flen = (frame_len == 0) ? FLEN_W'(1) : frame_len;
      value = (frame_pos == 0) ? r.coded_sample : prev_value + r.coded_sample;
      prev_value = value;
      if (int'(frame_pos) + 1 >= int'(flen)) frame_pos = '0;
      else frame_pos = frame_pos + 1'b1;
      if (sample_cnt == 0) begin
         run_max = value;
         run_min = value;
      end else begin
         if (value > run_max) run_max = value;
         if (value < run_min) run_min = value;
      end
      run_sum = run_sum + {{(SUM_W-VALUE_W){value[VALUE_W-1]}}, value};
      if (sample_cnt != '1) sample_cnt = sample_cnt + 1'b1;

      sample_rsp = '0;
      sample_rsp.kind = KIND_SAMPLE;
      sample_rsp.decoded_value = value;
      sample_rsp.last = !r.record_end;
      expected_q.insert(expected_q.size(), sample_rsp);
      if (r.record_end) begin
         summary_rsp = '0;
         summary_rsp.kind = KIND_SUMMARY;
         summary_rsp.maximum = run_max;
         summary_rsp.minimum = run_min;
         summary_rsp.average = record_mean();
         summary_rsp.total_count = sample_cnt[TOTAL_W-1:0];
         summary_rsp.last = 1'b1;
         expected_q.insert(expected_q.size(), summary_rsp);
         clear_record();
      end
   endfunction

   function string describe(rsp_type r);
      return $sformatf("kind %0d value %0d max %0d min %0d avg %0d count %0d last %0d",
                       r.kind, r.decoded_value, r.maximum, r.minimum, r.average,
                       r.total_count, r.last);
   endfunction

   function void check_rsp(rsp_type got);
      rsp_type want;
      if (expected_q.size() == 0) begin
         errors++;
         if (errors <= 10) $display("result with no request waiting: %s", describe(got));
         return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.decoded_value !== want.decoded_value ||
          got.maximum !== want.maximum || got.minimum !== want.minimum ||
          got.average !== want.average || got.total_count !== want.total_count ||
          got.last !== want.last) begin
         errors++;
         if (errors <= 10) begin
            $display("wrong result, expected %s", describe(want));
            $display("              actual   %s", describe(got));
         end
      end
   endfunction
endclass

module tb;
   localparam int LONG_HOLD = 300;
   localparam int PHASE_ITEMS = 205;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [FLEN_W-1:0] csr_data;

   stats_scoreboard   sb;
   bit                quiet = 1'b0;
   bit                start_hold = 1'b0;
   int                rec_left = 0;

   framed_delta_decoder_with_stats dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #6_000_000;
      $display("framed_delta_decoder_with_stats: mismatch");
      $finish;
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (start_hold) begin
            start_hold = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 4)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_rsp(rsp_data);
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_req(input logic [VALUE_W-1:0] coded, input logic rend);
      req_type item;
      item.coded_sample = coded;
      item.record_end = rend;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_req(item);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_frame_length(input logic [FLEN_W-1:0] len);
      wait_for_drain();
      csr_valid <= 1'b1;
      csr_data <= len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.frame_len = len;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // absolute values at frame starts, mostly small deltas inside a frame
   task automatic send_random_req();
      logic [VALUE_W-1:0] coded;
      if (rec_left == 0) begin
         rec_left = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(1, 16);
      end
      if (sb.frame_pos == 0 || $urandom_range(0, 7) == 0) coded = $urandom();
      else coded = VALUE_W'($urandom_range(0, 2000)) - VALUE_W'(1000);
      send_req(coded, rec_left == 1);
      rec_left--;
   endtask

   initial begin
      logic [FLEN_W-1:0] phase_len[8];
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      phase_len = '{8'd255, 8'd1, 8'd2, 8'd0, 8'd50, 8'd0, 8'd7, 8'd255};
      phase_len[5] = FLEN_W'($urandom_range(2, 254));
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset frame length: wrap at 32 bits, extremes of max and min
      send_req(32'h7FFF_FFFF, 1'b0);
      send_req(32'h0000_0001, 1'b0);
      send_req(32'hFFFF_FFFF, 1'b0);
      send_req(32'h8000_0000, 1'b1);
      // single-sample records at both extremes
      send_req(32'h8000_0000, 1'b1);
      send_req(32'h7FFF_FFFF, 1'b1);
      // negative mean truncates toward zero
      send_req(32'hFFFF_FFFF, 1'b0);
      send_req(32'h0000_0001, 1'b0);
      send_req(32'h0000_0000, 1'b1);

      // short frames: absolute value every third sample
      write_frame_length(8'd3);
      send_req(32'd100, 1'b0);
      send_req(32'd5, 1'b0);
      send_req(-32'sd10, 1'b0);
      send_req(32'd1000, 1'b0);
      send_req(32'd1, 1'b0);
      send_req(32'd1, 1'b0);
      send_req(-32'sd2000, 1'b1);

      // zero frame length acts as one: every sample absolute
      write_frame_length(8'd0);
      send_req(32'd10, 1'b0);
      send_req(32'd20, 1'b0);
      send_req(-32'sd30, 1'b1);

      for (int p = 0; p < 8; p++) begin
         quiet = (p == 7);
         write_frame_length(phase_len[p]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 2 && i == 40) start_hold = 1'b1;
            if (p == 4 && i == 100) wait_for_drain();
            send_random_req();
         end
      end

      wait_for_drain();
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("framed_delta_decoder_with_stats: match");
      end else begin
         $display("framed_delta_decoder_with_stats: mismatch");
      end
      $finish;
   end
endmodule

### filelist.f
rtl/fdd_pkg.sv
rtl/fdd_front.sv
rtl/fdd_queue.sv
rtl/fdd_back.sv
rtl/framed_delta_decoder_with_stats.sv
tb/tb.sv
